// ===== hw/rtl/split_direct_mapped_tlb_core_assert.svh =====
// Assertion macros used by the TLB core RTL.
`ifndef SPLIT_DIRECT_MAPPED_TLB_CORE_ASSERT_SVH
`define SPLIT_DIRECT_MAPPED_TLB_CORE_ASSERT_SVH

// Implication within the same cycle, disabled while in reset.
`define SDTLB_ASSERT_SAME(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("TLB assertion failed");

// Implication into the following cycle, disabled while in reset.
`define SDTLB_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("TLB assertion failed");

`endif

// ===== hw/rtl/sdtlb_pkg.sv =====
`default_nettype none

package sdtlb_pkg;

	// Default geometry.
	localparam int ITLB_INDEX_BITS_DEF = 8;
	localparam int DTLB_INDEX_BITS_DEF = 8;
	localparam int PAGE_SHIFT_DEF      = 12;

	// Field widths.
	localparam int OP_W     = 4;
	localparam int VA_W     = 32;
	localparam int HANDLE_W = 32;
	localparam int PERM_W   = 3;
	localparam int ENTRY_W  = 8;

	typedef logic [PERM_W-1:0] perm_t;

	// Permission bits.
	localparam perm_t PERM_X = 3'b001;
	localparam perm_t PERM_W_BIT = 3'b010;
	localparam perm_t PERM_R = 3'b100;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_IFETCH    = 4'd0;
	localparam logic [OP_W-1:0] OP_DREAD     = 4'd1;
	localparam logic [OP_W-1:0] OP_DWRITE    = 4'd2;
	localparam logic [OP_W-1:0] OP_FILL_I    = 4'd3;
	localparam logic [OP_W-1:0] OP_FILL_R    = 4'd4;
	localparam logic [OP_W-1:0] OP_FILL_W    = 4'd5;
	localparam logic [OP_W-1:0] OP_INV_I     = 4'd6;
	localparam logic [OP_W-1:0] OP_INV_D     = 4'd7;
	localparam logic [OP_W-1:0] OP_INV_ALL   = 4'd8;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [VA_W-1:0]     va;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] handle_out;
		logic [ENTRY_W-1:0]  entry_index;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sdtlb_table.sv =====
`default_nettype none

module sdtlb_table #(
	parameter int INDEX_BITS = sdtlb_pkg::ITLB_INDEX_BITS_DEF,
	parameter int TAG_W      = sdtlb_pkg::VA_W - sdtlb_pkg::PAGE_SHIFT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          rd_en,
	input  wire logic [INDEX_BITS-1:0]         rd_idx,
	input  wire logic                          wr_en,
	input  wire logic [INDEX_BITS-1:0]         wr_idx,
	input  wire logic [TAG_W-1:0]              wr_tag,
	input  wire sdtlb_pkg::perm_t              wr_perm,
	input  wire logic [sdtlb_pkg::HANDLE_W-1:0] wr_handle,
	input  wire logic                          inval,
	output logic                               ent_valid,
	output logic [TAG_W-1:0]                   ent_tag,
	output sdtlb_pkg::perm_t                   ent_perm,
	output logic [sdtlb_pkg::HANDLE_W-1:0]     ent_handle
);
	import sdtlb_pkg::*;

	localparam int DEPTH  = 1 << INDEX_BITS;
	localparam int WORD_W = TAG_W + PERM_W + HANDLE_W;

	logic [WORD_W-1:0]     mem [DEPTH];
	logic [DEPTH-1:0]      vld_q;
	logic [WORD_W-1:0]     rd_word_s1;
	logic [WORD_W-1:0]     fwd_word_s1;
	logic                  fwd_s1;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [WORD_W-1:0]     wr_word;
	logic [WORD_W-1:0]     word;

	assign wr_word = {wr_tag, wr_perm, wr_handle};

	// Entry store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_word;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_idx];
			idx_s1     <= rd_idx;
		end
		if (rd_en && wr_en && (rd_idx == wr_idx)) begin
			fwd_word_s1 <= wr_word;
		end
	end

	// A read that meets a write to the same slot takes the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (rd_en) begin
			fwd_s1 <= wr_en && (rd_idx == wr_idx);
		end
	end

	// Valid bits live in flip-flops so that a whole table clears at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (inval) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// An invalid slot reads as all zero.
	always_comb begin
		word       = fwd_s1 ? fwd_word_s1 : rd_word_s1;
		ent_valid  = vld_q[idx_s1];
		ent_tag    = ent_valid ? word[WORD_W-1 -: TAG_W] : '0;
		ent_perm   = ent_valid ? word[HANDLE_W +: PERM_W] : '0;
		ent_handle = ent_valid ? word[HANDLE_W-1:0] : '0;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/split_direct_mapped_tlb_core.sv =====
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_ready | sdtlb_pkg::req_t (op, va, handle_in)
// rsp     | out       | rsp_valid, rsp_ready | sdtlb_pkg::rsp_t (hit, handle_out, entry_index)
//
// One item is accepted per cycle unless the result register stalls; its result passes stage
// one and the result register. The rate is set by the single read port and single write port
// of each table memory: the read happens on acceptance, the write as the item leaves stage
// one, with forwarding between them. Reset clears the valid bits at once, so no sweep follows
// reset. A stalled result register holds the item in flight, and req_ready then drops.
`default_nettype none

`include "split_direct_mapped_tlb_core_assert.svh"

module split_direct_mapped_tlb_core #(
	parameter int ITLB_INDEX_BITS = sdtlb_pkg::ITLB_INDEX_BITS_DEF,
	parameter int DTLB_INDEX_BITS = sdtlb_pkg::DTLB_INDEX_BITS_DEF,
	parameter int PAGE_SHIFT      = sdtlb_pkg::PAGE_SHIFT_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire sdtlb_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output sdtlb_pkg::rsp_t      rsp
);
	import sdtlb_pkg::*;

	localparam int TAG_W = VA_W - PAGE_SHIFT;

	logic                       accept;
	logic                       advance;
	logic [TAG_W-1:0]           page_in;
	logic                       s1_valid;
	logic [OP_W-1:0]            op_s1;
	logic [TAG_W-1:0]           page_s1;
	logic [HANDLE_W-1:0]        hin_s1;
	logic                       rsp_valid_q;
	rsp_t                       rsp_q;
	rsp_t                       result;

	logic                       i_wr_en, d_wr_en, i_inval, d_inval;
	perm_t                      i_wr_perm, d_wr_perm;
	logic                       i_valid, d_valid;
	logic [TAG_W-1:0]           i_tag, d_tag;
	perm_t                      i_perm, d_perm;
	logic [HANDLE_W-1:0]        i_handle, d_handle;
	logic [ITLB_INDEX_BITS-1:0] i_slot_s1;
	logic [DTLB_INDEX_BITS-1:0] d_slot_s1;

	// Handshake: the stage moves on when the result register is free or being emptied.
	assign advance   = s1_valid && (!rsp_valid_q || rsp_ready);
	assign req_ready = !s1_valid || advance;
	assign accept    = req_valid && req_ready;
	assign page_in   = req.va[VA_W-1:PAGE_SHIFT];
	assign i_slot_s1 = page_s1[ITLB_INDEX_BITS-1:0];
	assign d_slot_s1 = page_s1[DTLB_INDEX_BITS-1:0];

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_ready) begin
			s1_valid <= req_valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.op;
			page_s1 <= page_in;
			hin_s1  <= req.handle_in;
		end
	end

	// Write-back decode for fills and invalidates.
	always_comb begin
		i_wr_en   = advance && (op_s1 == OP_FILL_I);
		d_wr_en   = advance && ((op_s1 == OP_FILL_R) || (op_s1 == OP_FILL_W));
		i_inval   = advance && ((op_s1 == OP_INV_I) || (op_s1 == OP_INV_ALL));
		d_inval   = advance && ((op_s1 == OP_INV_D) || (op_s1 == OP_INV_ALL));
		i_wr_perm = i_perm | PERM_R | PERM_X;
		d_wr_perm = d_perm | ((op_s1 == OP_FILL_R) ? PERM_R : PERM_W_BIT);
	end

	sdtlb_table #(
		.INDEX_BITS (ITLB_INDEX_BITS),
		.TAG_W      (TAG_W)
	) u_itlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_idx     (page_in[ITLB_INDEX_BITS-1:0]),
		.wr_en      (i_wr_en),
		.wr_idx     (i_slot_s1),
		.wr_tag     (page_s1),
		.wr_perm    (i_wr_perm),
		.wr_handle  (hin_s1),
		.inval      (i_inval),
		.ent_valid  (i_valid),
		.ent_tag    (i_tag),
		.ent_perm   (i_perm),
		.ent_handle (i_handle)
	);

	sdtlb_table #(
		.INDEX_BITS (DTLB_INDEX_BITS),
		.TAG_W      (TAG_W)
	) u_dtlb (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_idx     (page_in[DTLB_INDEX_BITS-1:0]),
		.wr_en      (d_wr_en),
		.wr_idx     (d_slot_s1),
		.wr_tag     (page_s1),
		.wr_perm    (d_wr_perm),
		.wr_handle  (hin_s1),
		.inval      (d_inval),
		.ent_valid  (d_valid),
		.ent_tag    (d_tag),
		.ent_perm   (d_perm),
		.ent_handle (d_handle)
	);

	// Lookup result: valid entry, tag match and every needed permission bit set; fills give the slot.
	always_comb begin
		result = '0;
		unique case (op_s1) inside
			OP_IFETCH: begin
				result.entry_index = ENTRY_W'(i_slot_s1);
				if (i_valid && (i_tag == page_s1) &&
				    ((i_perm & (PERM_R | PERM_X)) == (PERM_R | PERM_X))) begin
					result.hit        = 1'b1;
					result.handle_out = i_handle;
				end
			end
			OP_DREAD, OP_DWRITE: begin
				result.entry_index = ENTRY_W'(d_slot_s1);
				if (d_valid && (d_tag == page_s1) &&
				    ((d_perm & ((op_s1 == OP_DREAD) ? PERM_R : PERM_W_BIT)) != '0)) begin
					result.hit        = 1'b1;
					result.handle_out = d_handle;
				end
			end
			OP_FILL_I: begin
				result.entry_index = ENTRY_W'(i_slot_s1);
			end
			OP_FILL_R, OP_FILL_W: begin
				result.entry_index = ENTRY_W'(d_slot_s1);
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks on the pipeline and the result.
	`SDTLB_ASSERT_SAME(a_miss_zero, clk, arst_n, rsp_valid_q && !rsp_q.hit, rsp_q.handle_out == '0)
	`SDTLB_ASSERT_SAME(a_stall_blocks, clk, arst_n, s1_valid && rsp_valid_q && !rsp_ready, !req_ready)
	`SDTLB_ASSERT_NEXT(a_advance_shows, clk, arst_n, advance, rsp_valid_q)
	`SDTLB_ASSERT_NEXT(a_accept_fills, clk, arst_n, accept, s1_valid)
	`SDTLB_ASSERT_SAME(a_one_table, clk, arst_n, 1'b1, !(i_wr_en && d_wr_en) && !(i_wr_en && i_inval))

endmodule

`default_nettype wire
